/* rtl/bcd_signed_add_sub_unit_defines.svh */
// Assertion helpers for the signed BCD add/subtract unit.
`ifndef BCD_SIGNED_ADD_SUB_UNIT_DEFINES_SVH
`define BCD_SIGNED_ADD_SUB_UNIT_DEFINES_SVH

// Clocked check, off while reset is high.
`define BSAS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define BSAS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/bsas_pkg.sv */
package bsas_pkg;

   localparam int DIGITS = 16;
   localparam int MAG_W  = DIGITS * 4;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef logic [MAG_W-1:0] mag_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] a_digits;
      logic        a_negative;
      logic [63:0] b_digits;
      logic        b_negative;
   } req_type;

   typedef struct packed {
      logic [63:0] result_digits;
      logic        result_negative;
      logic        overflow;
   } rsp_type;

   // Read invalid digits as nine.
   function automatic mag_type clamp_digits(mag_type v);
      mag_type r;
      r = v;
      for (int i = 0; i < DIGITS; i++) begin
         if (v[4*i +: 4] > 4'd9) begin
            r[4*i +: 4] = 4'd9;
         end
      end
      return r;
   endfunction

   // Nine's complement of every digit.
   function automatic mag_type nines_digits(mag_type v);
      mag_type r;
      for (int i = 0; i < DIGITS; i++) begin
         r[4*i +: 4] = 4'd9 - v[4*i +: 4];
      end
      return r;
   endfunction

endpackage

/* rtl/bsas_bcd_adder.sv */
module bsas_bcd_adder
   import bsas_pkg::*;
(
   input  mag_type x,
   input  mag_type y,
   input  logic    cin,
   output mag_type sum,
   output logic    cout
);

   mag_type            bias;
   mag_type            x_biased;
   logic [MAG_W:0]     raw;
   logic [DIGITS-1:0]  carry;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bias[4*i +: 4] = 4'h6;
      end
   end

   assign x_biased = x + bias;
   assign raw      = {1'b0, x_biased} + {1'b0, y} + {{MAG_W{1'b0}}, cin};

   always_comb begin
      for (int i = 0; i < DIGITS - 1; i++) begin
         carry[i] = raw[4*i+4] ^ x_biased[4*i+4] ^ y[4*i+4];
      end
      carry[DIGITS-1] = raw[MAG_W];
      for (int i = 0; i < DIGITS; i++) begin
         sum[4*i +: 4] = carry[i] ? raw[4*i +: 4] : raw[4*i +: 4] - 4'h6;
      end
   end

   assign cout = raw[MAG_W];

endmodule

/* rtl/bsas_datapath.sv */
module bsas_datapath
   import bsas_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   mag_type a_mag;
   mag_type b_mag;
   mag_type sum_ab;
   mag_type dif_ab;
   mag_type dif_ba;
   logic    c_sum;
   logic    a_ge_b;
   logic    c_ba;
   logic    b_neg_eff;
   mag_type mag;
   logic    neg;
   logic    ovf;

   assign a_mag     = clamp_digits(req.a_digits[MAG_W-1:0]);
   assign b_mag     = clamp_digits(req.b_digits[MAG_W-1:0]);
   assign b_neg_eff = req.b_negative ^ (req.opcode == OP_SUB);

   bsas_bcd_adder u_sum (
      .x(a_mag), .y(b_mag), .cin(1'b0), .sum(sum_ab), .cout(c_sum)
   );

   bsas_bcd_adder u_dif_ab (
      .x(a_mag), .y(nines_digits(b_mag)), .cin(1'b1), .sum(dif_ab), .cout(a_ge_b)
   );

   bsas_bcd_adder u_dif_ba (
      .x(b_mag), .y(nines_digits(a_mag)), .cin(1'b1), .sum(dif_ba), .cout(c_ba)
   );

   always_comb begin
      mag = a_mag;
      neg = req.a_negative;
      ovf = 1'b0;
      unique case (req.opcode) inside
         OP_ADD, OP_SUB: begin
            if (req.a_negative == b_neg_eff) begin
               mag = sum_ab;
               ovf = c_sum;
            end else if (c_ba && !a_ge_b) begin
               mag = dif_ba;
               neg = b_neg_eff;
            end else begin
               mag = dif_ab;
            end
         end
         OP_MUL: begin
            if (a_mag[MAG_W-1 -: 4] != 4'd0) begin
               ovf = 1'b1;
            end else begin
               mag = {a_mag[MAG_W-5:0], 4'h0};
            end
         end
         OP_DIV: begin
            mag = {4'h0, a_mag[MAG_W-1:4]};
         end
         default: begin
            mag = a_mag;
         end
      endcase
      if (mag == '0) begin
         neg = 1'b0;
      end
   end

   assign rsp.result_digits   = 64'(mag);
   assign rsp.result_negative = neg;
   assign rsp.overflow        = ovf;

endmodule

/* rtl/bcd_signed_add_sub_unit.sv */
// Signed BCD add, subtract, times ten and divide by ten. One operation is taken
// in every clock cycle (busy stays low); it passes the input register and the
// result register, and its result appears on rsp_data with rsp_valid high for
// exactly one cycle. Results come out in order and cannot be held off, so the
// receiver must take every result in the cycle it is shown. The path between the
// input register and the result register holds three 64-bit BCD carry chains.
`include "bcd_signed_add_sub_unit_defines.svh"

module bcd_signed_add_sub_unit
   import bsas_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_neg_zero;
   logic    req_is_div;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // Hold payload without reset.
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   bsas_datapath u_datapath (
      .req(req_ff),
      .rsp(rsp_in)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_neg_zero = rsp_data.result_negative && (rsp_data.result_digits == 64'd0);
   assign req_is_div   = (req_data.opcode == OP_DIV);

   `BSAS_ASSERT(a_latency, (start && !busy) |-> ##2 rsp_valid, "result missing after transfer")
   `BSAS_ASSERT(a_zero_pos, rsp_valid |-> !rsp_neg_zero, "negative zero result")
   `BSAS_ASSERT(a_div, rsp_valid && $past(req_is_div, 2) |-> !rsp_data.overflow, "divide flagged")
   `BSAS_ASSERT_RST(a_reset, reset |=> !rsp_valid, "result strobe after reset")

endmodule
